// File: design/hxk_pkg.sv
// Package for the repeating-key XOR hex decoder: item types, status codes,
// key tables and the hex digit / key byte helper functions. No dependencies.
package hxk_pkg;

    // Character codes used by the digit decoder
    localparam logic [7:0] CHAR_DASH   = 8'h2d;  // '-'
    localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE   = 8'h39;  // '9'
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LOW_F  = 8'h66;  // 'f'
    localparam logic [7:0] CHAR_UP_A   = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_UP_F   = 8'h46;  // 'F'
    localparam logic [4:0] DIGIT_TEN   = 5'd10;

    // Key tables; key byte i is TA[i] ^ TB[i] ^ KEY_MASK
    localparam int         TABLE_LEN = 18;
    localparam int         KPOS_W    = 5;
    localparam logic [7:0] KEY_MASK  = 8'h5a;

    localparam logic [7:0] KEY_TA [TABLE_LEN] = '{
        8'h54, 8'h32, 8'h11, 8'h78, 8'h22, 8'h65, 8'h43, 8'h19,
        8'h88, 8'h71, 8'h24, 8'h90, 8'h55, 8'h17, 8'h33, 8'h44, 8'h55, 8'h66
    };
    localparam logic [7:0] KEY_TB [TABLE_LEN] = '{
        8'h5a, 8'h1b, 8'h3e, 8'h5b, 8'h0d, 8'h6c, 8'h7c, 8'h20,
        8'ha0, 8'h4e, 8'h0a, 8'h81, 8'h6a, 8'h34, 8'h5b, 8'h2e, 8'h3d, 8'h0a
    };

    // End-of-string status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_ODD   = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    // Input item
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_string;
        t_status    status;
    } t_out;

    // Decode one hex character: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        logic [7:0] d;
        r = 5'd0;
        d = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
            r = {1'b1, d[3:0]};
        end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
            d = c - CHAR_LOW_A + 8'(DIGIT_TEN);
            r = {1'b1, d[3:0]};
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            d = c - CHAR_UP_A + 8'(DIGIT_TEN);
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

    // Key byte for a key position below 32; positions past the table wrap once
    function automatic logic [7:0] key_byte(input logic [KPOS_W-1:0] pos);
        logic [KPOS_W-1:0] t;
        t = (pos >= KPOS_W'(TABLE_LEN)) ? pos - KPOS_W'(TABLE_LEN) : pos;
        return KEY_TA[t] ^ KEY_TB[t] ^ KEY_MASK;
    endfunction

endpackage

// File: design/hxk_decode.sv
// Input register and per-string decode state for the hex XOR decoder.
// Depends on hxk_pkg for item types, the digit decoder and the key table.
module hxk_decode #(
    parameter int KEY_BYTES = 18
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  hxk_pkg::t_in i_in,
    input  logic         i_adv,
    output logic         o_res_valid,
    output hxk_pkg::t_out o_res
);
    import hxk_pkg::*;

    localparam int KPW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    logic           r_in_valid;
    t_in            r_in;
    logic           r_pend, n_pend;
    logic [3:0]     r_high, n_high;
    logic [KPW-1:0] r_kpos, n_kpos;
    logic           r_bad, n_bad;
    logic           r_digit, n_digit;

    logic           w_dash;
    logic [4:0]     w_dig;
    logic [3:0]     w_val;
    logic           w_done;
    logic           w_have;
    logic           w_step;
    logic           w_pend_end;
    logic [KPW:0]   w_kinc;

    // Hold the input item while the result side is blocked
    assign o_in_stall = r_in_valid && !i_adv;
    assign w_step     = r_in_valid && i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Decode the held character against the string state
    always_comb begin
        w_dash  = (r_in.in_char == CHAR_DASH);
        w_dig   = hex_digit(r_in.in_char);
        w_val   = w_dig[4] ? w_dig[3:0] : 4'd0;
        n_bad   = r_bad || (!w_dash && !w_dig[4]);
        n_digit = r_digit || !w_dash;
        w_done  = !w_dash && r_pend;
        w_have  = w_done && !n_bad;
        w_kinc  = {1'b0, r_kpos} + 1'b1;

        n_pend = r_pend;
        n_high = r_high;
        n_kpos = r_kpos;
        if (!w_dash) begin
            if (!r_pend) begin
                n_pend = 1'b1;
                n_high = w_val;
            end else begin
                n_pend = 1'b0;
                n_high = 4'd0;
                n_kpos = (w_kinc >= (KPW+1)'(KEY_BYTES)) ? '0 : w_kinc[KPW-1:0];
            end
        end
        w_pend_end = n_pend;

        // Drop all string state after the last character
        if (r_in.in_last) begin
            n_pend  = 1'b0;
            n_high  = 4'd0;
            n_kpos  = '0;
            n_bad   = 1'b0;
            n_digit = 1'b0;
        end

        o_res_valid = r_in_valid && (w_have || r_in.in_last);
        o_res.out_byte      = w_have ? ({r_high, w_val} ^ key_byte(KPOS_W'(r_kpos))) : 8'd0;
        o_res.byte_valid    = w_have;
        o_res.end_of_string = r_in.in_last;
        priority if (!r_in.in_last) begin
            o_res.status = ST_OK;
        end else if (!(r_digit || !w_dash)) begin
            o_res.status = ST_EMPTY;
        end else if (w_pend_end) begin
            o_res.status = ST_ODD;
        end else if (r_bad || (!w_dash && !w_dig[4])) begin
            o_res.status = ST_BAD;
        end else begin
            o_res.status = ST_OK;
        end
    end

    // Advance string state when the held item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_high  <= 4'd0;
            r_kpos  <= '0;
            r_bad   <= 1'b0;
            r_digit <= 1'b0;
        end else if (w_step) begin
            r_pend  <= n_pend;
            r_high  <= n_high;
            r_kpos  <= n_kpos;
            r_bad   <= n_bad;
            r_digit <= n_digit;
        end
    end

endmodule

// File: design/hxk_out_reg.sv
// Result register for the hex XOR decoder; takes a new item whenever empty
// or being drained. Depends on hxk_pkg for the result item type.
module hxk_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_res_valid,
    input  hxk_pkg::t_out i_res,
    output logic          o_adv,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output hxk_pkg::t_out o_out
);
    import hxk_pkg::*;

    logic r_valid;
    t_out r_out;

    // Free when empty or when the held item leaves this cycle
    assign o_adv = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_res_valid;
        end
        if (o_adv && i_res_valid) begin
            r_out <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

// File: design/hex_xor_key_decoder_core.sv
// Repeating-key XOR hex decoder: one character item in, zero or one result out.
// The accepting edge loads the input register; decode and key XOR then load the
// result register once it is free. Throughput: 1 item per cycle while the result
// side does not stall, as the nibble flag and key counter update once per item.
// Reset (synchronous, active low) empties both registers and clears the
// per-string state; the block accepts items in the first cycle after reset.
module hex_xor_key_decoder_core #(
    parameter int KEY_BYTES = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  hxk_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output hxk_pkg::t_out o_out
);
    import hxk_pkg::*;

    logic w_adv;
    logic w_res_valid;
    t_out w_res;

    // Decode stage with string state
    hxk_decode #(
        .KEY_BYTES (KEY_BYTES)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_adv       (w_adv),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Result register
    hxk_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// File: dv/hex_xor_key_decoder_core_test.sv
`timescale 1ns / 1ps
// Testbench for hex_xor_key_decoder_core: sends hex text items, predicts the decoded
// bytes and end-of-string statuses, and checks every result in order.
// Depends on hxk_pkg and the core; it needs no files or arguments.
module hex_xor_key_decoder_core_test;

    import hxk_pkg::*;

    localparam int KEY_LEN     = 18;    // matches the core's default key length
    localparam int WATCH_LIMIT = 1000;  // cycles with no item moving before giving up
    localparam int PRINT_LIMIT = 50;

    // Key tables kept apart from the package so a table slip in the core shows up
    localparam logic [7:0] KEY_A [18] = '{
        8'h54, 8'h32, 8'h11, 8'h78, 8'h22, 8'h65, 8'h43, 8'h19,
        8'h88, 8'h71, 8'h24, 8'h90, 8'h55, 8'h17, 8'h33, 8'h44, 8'h55, 8'h66
    };
    localparam logic [7:0] KEY_B [18] = '{
        8'h5a, 8'h1b, 8'h3e, 8'h5b, 8'h0d, 8'h6c, 8'h7c, 8'h20,
        8'ha0, 8'h4e, 8'h0a, 8'h81, 8'h6a, 8'h34, 8'h5b, 8'h2e, 8'h3d, 8'h0a
    };
    localparam logic [7:0] KEY_XOR = 8'h5a;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_in   i_in        = '0;
    logic  i_out_stall = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_out  o_out;

    hex_xor_key_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // Decoder state as the predictor sees it
    logic       half_pending = 1'b0;
    logic [3:0] upper_nib    = 4'd0;
    int         key_index    = 0;
    logic       saw_bad      = 1'b0;
    logic       saw_digit    = 1'b0;

    t_out        decoded_q [$];
    bit          idle_en        = 1'b0;
    int unsigned stall_left     = 0;
    int unsigned mismatches     = 0;
    int unsigned chars_sent     = 0;
    int unsigned strings_sent   = 0;
    int unsigned results_seen   = 0;
    int unsigned bytes_seen     = 0;
    int unsigned status_count [4] = '{0, 0, 0, 0};
    int unsigned quiet_cycles   = 0;

    // Hex digit value of a character, -1 when it is no hex digit
    function automatic int char_value(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            return int'(c) - int'(CHAR_ZERO);
        if (c >= CHAR_LOW_A && c <= CHAR_LOW_F)
            return int'(c) - int'(CHAR_LOW_A) + int'(DIGIT_TEN);
        if (c >= CHAR_UP_A && c <= CHAR_UP_F)
            return int'(c) - int'(CHAR_UP_A) + int'(DIGIT_TEN);
        return -1;
    endfunction

    function automatic logic [7:0] key_for_position(input int pos);
        int t;
        t = (pos % KEY_LEN) % 18;
        return KEY_A[t] ^ KEY_B[t] ^ KEY_XOR;
    endfunction

    // Advance the predicted decoder by one character; return 1 when it gives a result
    function automatic bit decode_char(input t_in item, output t_out res);
        int         v;
        logic [3:0] nib;
        bit         emit;
        res        = '0;
        res.status = ST_OK;
        emit       = 1'b0;
        if (item.in_char != CHAR_DASH) begin
            saw_digit = 1'b1;
            v = char_value(item.in_char);
            if (v < 0) begin
                saw_bad = 1'b1;
                v = 0;
            end
            nib = 4'(v);
            if (!half_pending) begin
                upper_nib    = nib;
                half_pending = 1'b1;
            end else begin
                if (!saw_bad) begin
                    res.out_byte   = {upper_nib, nib} ^ key_for_position(key_index);
                    res.byte_valid = 1'b1;
                    emit           = 1'b1;
                end
                half_pending = 1'b0;
                upper_nib    = 4'd0;
                key_index    = (key_index + 1 >= KEY_LEN) ? 0 : key_index + 1;
            end
        end
        if (item.in_last) begin
            res.end_of_string = 1'b1;
            if (!saw_digit)
                res.status = ST_EMPTY;
            else if (half_pending)
                res.status = ST_ODD;
            else if (saw_bad)
                res.status = ST_BAD;
            else
                res.status = ST_OK;
            status_count[res.status]++;
            emit         = 1'b1;
            half_pending = 1'b0;
            upper_nib    = 4'd0;
            key_index    = 0;
            saw_bad      = 1'b0;
            saw_digit    = 1'b0;
        end
        return emit;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Send one character item; hold it until accepted, then record what it should give
    task automatic send_char(input logic [7:0] c, input logic last);
        t_in         item;
        t_out        res;
        int unsigned gap;
        item.in_char = c;
        item.in_last = last;
        if (idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall);
        if (decode_char(item, res))
            decoded_q.push_back(res);
        chars_sent++;
        if (last)
            strings_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return CHAR_ZERO + 8'(nib);
        if ($urandom_range(0, 1) != 0)
            return CHAR_UP_A + 8'(nib - 4'd10);
        return CHAR_LOW_A + 8'(nib - 4'd10);
    endfunction

    // Build one string: mostly well-formed hex with dashes, some odd, some with a bad
    // character, some pure noise
    task automatic send_random_string(input int unsigned max_bytes);
        logic [7:0]  text [$];
        logic [7:0]  c;
        int unsigned kind;
        int unsigned pos;
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, max_bytes)) begin
                if ($urandom_range(0, 5) == 0)
                    text.push_back(CHAR_DASH);
                text.push_back(hex_char(4'($urandom_range(0, 15))));
                text.push_back(hex_char(4'($urandom_range(0, 15))));
            end
            if (kind == 7)
                text.push_back(hex_char(4'($urandom_range(0, 15))));
            if (kind == 8) begin
                do c = 8'($urandom_range(0, 255));
                while (char_value(c) >= 0 || c == CHAR_DASH);
                pos = $urandom_range(0, text.size());
                if (pos < text.size() && $urandom_range(0, 1) != 0)
                    text[pos] = c;
                else
                    text.insert(pos, c);
            end
            if ($urandom_range(0, 5) == 0)
                text.push_back(CHAR_DASH);
            if (text.size() == 0)
                text.push_back(CHAR_DASH);
        end
        foreach (text[i])
            send_char(text[i], i == text.size() - 1);
    endtask

    // Each end status, including the priority of empty over odd over bad
    task automatic test_status_codes();
        send_text("-");                 // dashes only: empty
        send_text("0");                 // lone digit: odd, digit dropped
        send_text("G");                 // lone bad char: odd wins over bad
        send_char(8'h00, 1'b0);         // NUL is a bad char, byte suppressed
        send_text("F");
        send_char(8'hff, 1'b0);         // top code is a bad char too
        send_text("1");
        send_text("9-aF");              // dash skipped, one byte, then odd
        send_text("9A-");               // byte emitted, dash carries the end
    endtask

    // Digit extremes, a zero decoded byte, and a byte completed by the last char
    task automatic test_byte_extremes();
        send_text("ff");
        send_text("54");                // first key byte is 0x54, so this decodes to zero
        send_text("00Ff");
    endtask

    // Long strings so the key index wraps more than once
    task automatic test_key_wrap();
        repeat (4) begin
            for (int i = 0; i < 2 * (KEY_LEN + 20); i++)
                send_char(hex_char(4'($urandom_range(0, 15))), i == 2 * (KEY_LEN + 20) - 1);
        end
    endtask

    task automatic test_random_strings();
        idle_en = 1'b1;
        while (chars_sent < 1200) begin
            if ($urandom_range(0, 9) == 0)
                idle_en = !idle_en;
            send_random_string(($urandom_range(0, 7) == 0) ? 40 : 12);
        end
    endtask

    // Finish with no idling on either side
    task automatic test_back_to_back();
        idle_en = 1'b0;
        while (chars_sent < 1350)
            send_random_string(12);
    endtask

    // Stall the result side in random bursts while idling is enabled
    always @(posedge i_clk) begin
        if (!idle_en) begin
            stall_left = 0;
        end else if (stall_left == 0 && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18);
        end
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic check_result(input t_out got);
        t_out want;
        if (decoded_q.size() == 0) begin
            report_mismatch("result with nothing pending", 32'(got), 32'd0);
            return;
        end
        want = decoded_q.pop_front();
        results_seen++;
        if (want.byte_valid)
            bytes_seen++;
        if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
        if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
        if (got.end_of_string !== want.end_of_string)
            report_mismatch("end_of_string", 32'(got.end_of_string),
                            32'(want.end_of_string));
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
    endtask

    // Check each result as it is taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            check_result(o_out);
    end

    // Watchdog: end the run when no item moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("watchdog: no item moved in %0d cycles", WATCH_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_status_codes();
        test_byte_extremes();
        test_key_wrap();
        test_random_strings();
        test_back_to_back();
        i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (decoded_q.size() != 0)
            report_mismatch("results never produced", 32'(decoded_q.size()), 32'd0);
        $display("Sent %0d characters in %0d strings; checked %0d results, %0d decoded bytes.",
                 chars_sent, strings_sent, results_seen, bytes_seen);
        $display("End statuses ok/empty/odd/bad: %0d/%0d/%0d/%0d; mismatches: %0d",
                 status_count[ST_OK], status_count[ST_EMPTY], status_count[ST_ODD],
                 status_count[ST_BAD], mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
